[src/pkhw_pkg.sv]
// shared constants and widths for the per-key history window
`timescale 1ns / 1ps

package pkhw_pkg;

   // payload field widths
   localparam int KEY_W    = 32;
   localparam int ROW_W    = 16;
   localparam int POS_W    = 5;
   localparam int LIMIT_W  = 6;

   // most history entries reported for one row
   localparam int MAX_REPORT = 32;

   // default ring depth
   localparam int HIST_DEPTH_DEF = 32;

   // reset values
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32);
   localparam logic [KEY_W-1:0]   NO_USER     = '1;

endpackage

[src/pkhw_if.sv]
// request and response channel interfaces for the per-key history window
`timescale 1ns / 1ps

interface pkhw_req_if
   import pkhw_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] user_key;
   logic [KEY_W-1:0] item_key;
   logic [KEY_W-1:0] rating_bits;
   logic [ROW_W-1:0] row_index;

   modport source (output valid, user_key, item_key, rating_bits, row_index, input ready);
   modport sink   (input valid, user_key, item_key, rating_bits, row_index, output ready);
endinterface

interface pkhw_rsp_if
   import pkhw_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [ROW_W-1:0]   out_row_index;
   logic [POS_W-1:0]   history_position;
   logic [KEY_W-1:0]   history_item;
   logic [KEY_W-1:0]   history_rating;
   logic [LIMIT_W-1:0] history_count;
   logic               history_empty;
   logic               last_of_run;

   modport source (output valid, out_row_index, history_position, history_item,
                   history_rating, history_count, history_empty, last_of_run,
                   input ready);
   modport sink   (input valid, out_row_index, history_position, history_item,
                   history_rating, history_count, history_empty, last_of_run,
                   output ready);
endinterface

[src/per_key_history_window.sv]
// Per-key history window: rows grouped by user arrive on req_ch one word at a time. A change of
// user_key clears the stored history. Each row then yields its history on rsp_ch: the last
// min(count, history_limit, HIST_DEPTH, 32) earlier item/rating pairs of the same user, oldest
// first, or one word flagged history_empty when there is none. After its history the row is
// appended to a ring of HIST_DEPTH entries held in a single-port-read memory. A row is accepted
// in S_IDLE, its history is streamed in S_STREAM from the one memory read port at one entry per
// cycle while rsp_ch is not stalled (back pressure on rsp_ch holds the stream), and the row is
// appended in S_APPEND. req_ch.ready is high only between rows.
// history_limit is written through csr_wr_en / csr_wr_data and resets to 32.
`timescale 1ns / 1ps

module per_key_history_window
   import pkhw_pkg::*;
#(
   parameter int HIST_DEPTH = HIST_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   pkhw_req_if.sink           req_ch,
   pkhw_rsp_if.source         rsp_ch,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data
);

   localparam int HeadW  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int CntW   = $clog2(HIST_DEPTH + 1);
   localparam int CalcW  = CntW + 1;
   localparam int CmpW   = (CntW > LIMIT_W) ? CntW : LIMIT_W;
   localparam int MaxRep = (HIST_DEPTH < MAX_REPORT) ? HIST_DEPTH : MAX_REPORT;
   localparam int DataW  = 2 * KEY_W;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_STREAM = 3'b010,
      S_APPEND = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [KEY_W-1:0]   user_ff, user_in;
   logic [HeadW-1:0]   head_ff, head_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [KEY_W-1:0]   item_ff, item_in;
   logic [KEY_W-1:0]   rating_ff, rating_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [LIMIT_W-1:0] n_ff, n_in;
   logic [POS_W-1:0]   k_ff, k_in;
   logic [HeadW-1:0]   ptr_ff, ptr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]   out_row_ff, out_row_in;
   logic [POS_W-1:0]   out_pos_ff, out_pos_in;
   logic [LIMIT_W-1:0] out_cnt_ff, out_cnt_in;
   logic               out_empty_ff, out_empty_in;
   logic               out_last_ff, out_last_in;
   logic [DataW-1:0]   rd_data_ff;

   logic [DataW-1:0]   ring_mem [HIST_DEPTH];

   logic               accept;
   logic               new_user;
   logic [CntW-1:0]    cnt_eff;
   logic [HeadW-1:0]   head_eff;
   logic [LIMIT_W-1:0] lim_eff;
   logic [LIMIT_W-1:0] n_calc;
   logic [CalcW-1:0]   start_calc;
   logic               advance;
   logic               run_empty;
   logic               run_last;
   logic               rd_en;
   logic               wr_en;
   logic [HeadW-1:0]   ptr_next;
   logic [HeadW-1:0]   head_next;

   assign accept = req_ch.valid && req_ch.ready;

   // effective history at accept: a new user starts from an empty ring
   always_comb begin
      new_user = (req_ch.user_key != user_ff);
      cnt_eff  = new_user ? '0 : count_ff;
      head_eff = new_user ? '0 : head_ff;
      lim_eff  = (limit_ff > LIMIT_W'(MaxRep)) ? LIMIT_W'(MaxRep) : limit_ff;
      n_calc   = (CmpW'(cnt_eff) < CmpW'(lim_eff)) ? LIMIT_W'(cnt_eff) : lim_eff;
      // oldest reported slot, head - n modulo the depth
      if (CalcW'(head_eff) >= CalcW'(n_calc)) begin
         start_calc = CalcW'(head_eff) - CalcW'(n_calc);
      end else begin
         start_calc = CalcW'(head_eff) + CalcW'(HIST_DEPTH) - CalcW'(n_calc);
      end
   end

   // wrapping increments of read pointer and head
   always_comb begin
      ptr_next  = (ptr_ff == HeadW'(HIST_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
      head_next = (head_ff == HeadW'(HIST_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   end

   // stream control
   always_comb begin
      advance   = !rsp_valid_ff || rsp_ch.ready;
      run_empty = (n_ff == '0);
      run_last  = (({1'b0, k_ff} + LIMIT_W'(1)) == n_ff);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      user_in      = user_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      limit_in     = limit_ff;
      item_in      = item_ff;
      rating_in    = rating_ff;
      row_in       = row_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      ptr_in       = ptr_ff;
      rsp_valid_in = rsp_valid_ff;
      out_row_in   = out_row_ff;
      out_pos_in   = out_pos_ff;
      out_cnt_in   = out_cnt_ff;
      out_empty_in = out_empty_ff;
      out_last_in  = out_last_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;

      if (csr_wr_en) begin
         limit_in = csr_wr_data;
      end

      // output word taken
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               user_in   = req_ch.user_key;
               count_in  = cnt_eff;
               head_in   = head_eff;
               item_in   = req_ch.item_key;
               rating_in = req_ch.rating_bits;
               row_in    = req_ch.row_index;
               n_in      = n_calc;
               k_in      = '0;
               ptr_in    = HeadW'(start_calc);
               state_in  = S_STREAM;
            end
         end
         S_STREAM: begin
            if (advance) begin
               rsp_valid_in = 1'b1;
               out_row_in   = row_ff;
               out_pos_in   = k_ff;
               out_cnt_in   = n_ff;
               out_empty_in = run_empty;
               out_last_in  = run_empty || run_last;
               rd_en        = !run_empty;
               k_in         = k_ff + 1'b1;
               ptr_in       = ptr_next;
               if (run_empty || run_last) begin
                  state_in = S_APPEND;
               end
            end
         end
         S_APPEND: begin
            wr_en    = 1'b1;
            head_in  = head_next;
            count_in = (count_ff == CntW'(HIST_DEPTH)) ? count_ff : count_ff + 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         user_ff      <= NO_USER;
         head_ff      <= '0;
         count_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         user_ff      <= user_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      rating_ff    <= rating_in;
      row_ff       <= row_in;
      n_ff         <= n_in;
      k_ff         <= k_in;
      ptr_ff       <= ptr_in;
      out_row_ff   <= out_row_in;
      out_pos_ff   <= out_pos_in;
      out_cnt_ff   <= out_cnt_in;
      out_empty_ff <= out_empty_in;
      out_last_ff  <= out_last_in;
   end

   // history ring: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[head_ff] <= {item_ff, rating_ff};
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[ptr_ff];
      end
   end

   // channel outputs
   assign req_ch.ready            = (state_ff == S_IDLE);
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.out_row_index    = out_row_ff;
   assign rsp_ch.history_position = out_pos_ff;
   assign rsp_ch.history_item     = out_empty_ff ? '0 : rd_data_ff[DataW-1:KEY_W];
   assign rsp_ch.history_rating   = out_empty_ff ? '0 : rd_data_ff[KEY_W-1:0];
   assign rsp_ch.history_count    = out_cnt_ff;
   assign rsp_ch.history_empty    = out_empty_ff;
   assign rsp_ch.last_of_run      = out_last_ff;

endmodule

[src/pkhw_checker.sv]
// port-level assertions for the per-key history window, bound to the top level
`timescale 1ns / 1ps

module pkhw_checker
   import pkhw_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [POS_W-1:0]   rsp_pos,
   input logic [LIMIT_W-1:0] rsp_cnt,
   input logic               rsp_empty,
   input logic               rsp_last
);

   // busy right after a row is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("pkhw: ready high the cycle after an accept");

   // empty history is a single final word with zero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty |-> rsp_last && (rsp_cnt == '0) && (rsp_pos == '0))
      else $error("pkhw: malformed empty-history word");

   // a run continues without a gap and positions count up
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && (rsp_pos == $past(rsp_pos) + 5'd1))
      else $error("pkhw: history run broken or position skipped");

   // no new row is taken while a run is still open
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !(rsp_valid && !rsp_last))
      else $error("pkhw: ready while a history run is open");

   // stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_pos) && $stable(rsp_cnt) && $stable(rsp_last))
      else $error("pkhw: stalled response word changed");

endmodule

bind per_key_history_window pkhw_checker u_pkhw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_pos   (rsp_ch.history_position),
   .rsp_cnt   (rsp_ch.history_count),
   .rsp_empty (rsp_ch.history_empty),
   .rsp_last  (rsp_ch.last_of_run)
);

[test/per_key_history_window_tb.sv]
// testbench for the per-key history window: random rows against a history predictor
`timescale 1ns / 1ps

package pkhw_tb_pkg;
   import pkhw_pkg::*;

   // one input row
   typedef struct packed {
      logic [KEY_W-1:0] user_key;
      logic [KEY_W-1:0] item_key;
      logic [KEY_W-1:0] rating_bits;
      logic [ROW_W-1:0] row_index;
   } row_type;

   // one history word on the response channel
   typedef struct packed {
      logic [ROW_W-1:0]   out_row_index;
      logic [POS_W-1:0]   history_position;
      logic [KEY_W-1:0]   history_item;
      logic [KEY_W-1:0]   history_rating;
      logic [LIMIT_W-1:0] history_count;
      logic               history_empty;
      logic               last_of_run;
   } hist_word_type;

   class history_tracker;
      logic [KEY_W-1:0] ring_item [HIST_DEPTH_DEF];
      logic [KEY_W-1:0] ring_rating [HIST_DEPTH_DEF];
      int unsigned      head;
      int unsigned      stored;
      int unsigned      limit;
      logic [KEY_W-1:0] user;
      hist_word_type    pending_history [$];
      int               errors;

      function new();
         head   = 0;
         stored = 0;
         limit  = 32'(LIMIT_RESET);
         user   = NO_USER;
         errors = 0;
      endfunction

      function void set_limit(logic [LIMIT_W-1:0] value);
         limit = 32'(value);
      endfunction

      function int unsigned outstanding();
         return pending_history.size();
      endfunction

      // accepted row: queue its history words, then append it to the ring
      function void note_row(row_type r);
         hist_word_type w;
         int unsigned   n;
         int unsigned   slot;
         if (r.user_key != user) begin
            user   = r.user_key;
            stored = 0;
            head   = 0;
         end
         n = limit;
         if (n > HIST_DEPTH_DEF) n = HIST_DEPTH_DEF;
         if (n > MAX_REPORT) n = MAX_REPORT;
         if (n > stored) n = stored;
         if (n == 0) begin
            // empty history gives a single flagged word
            w               = '0;
            w.out_row_index = r.row_index;
            w.history_empty = 1'b1;
            w.last_of_run   = 1'b1;
            pending_history = {pending_history, w};
         end else begin
            for (int k = 0; k < n; k++) begin
               slot               = (head + HIST_DEPTH_DEF - n + k) % HIST_DEPTH_DEF;
               w.out_row_index    = r.row_index;
               w.history_position = POS_W'(k);
               w.history_item     = ring_item[slot];
               w.history_rating   = ring_rating[slot];
               w.history_count    = LIMIT_W'(n);
               w.history_empty    = 1'b0;
               w.last_of_run      = (k + 1 == n);
               pending_history = {pending_history, w};
            end
         end
         ring_item[head]   = r.item_key;
         ring_rating[head] = r.rating_bits;
         head              = (head + 1) % HIST_DEPTH_DEF;
         if (stored < HIST_DEPTH_DEF) stored++;
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      // accepted response word against the oldest expectation
      function void check_word(hist_word_type got);
         hist_word_type want;
         if (pending_history.size() == 0) begin
            $error("unexpected history word for row %0h", got.out_row_index);
            errors++;
            return;
         end
         want = pending_history.pop_front();
         compare_field("out_row_index", 32'(want.out_row_index), 32'(got.out_row_index));
         compare_field("history_position", 32'(want.history_position),
                       32'(got.history_position));
         compare_field("history_item", want.history_item, got.history_item);
         compare_field("history_rating", want.history_rating, got.history_rating);
         compare_field("history_count", 32'(want.history_count), 32'(got.history_count));
         compare_field("history_empty", 32'(want.history_empty), 32'(got.history_empty));
         compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
      endfunction
   endclass

endpackage

module per_key_history_window_tb;
   import pkhw_pkg::*;
   import pkhw_tb_pkg::*;

   localparam int SEGMENTS      = 6;
   localparam int SEGMENT_ROWS  = 14;
   localparam int ROW_LATENCY   = 40;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_wr_en;
   logic [LIMIT_W-1:0] csr_wr_data;
   int                 send_idle_pct;
   int                 recv_idle_pct;

   history_tracker hist = new();

   pkhw_req_if req_ch ();
   pkhw_rsp_if rsp_ch ();

   per_key_history_window dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // response side: check accepted words, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         hist.check_word('{rsp_ch.out_row_index, rsp_ch.history_position,
                           rsp_ch.history_item, rsp_ch.history_rating,
                           rsp_ch.history_count, rsp_ch.history_empty,
                           rsp_ch.last_of_run});
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // drive one row and hold it until the word is taken; valid stays high afterwards
   task automatic send_row(row_type r);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_ch.valid       <= 1'b1;
      req_ch.user_key    <= r.user_key;
      req_ch.item_key    <= r.item_key;
      req_ch.rating_bits <= r.rating_bits;
      req_ch.row_index   <= r.row_index;
      do @(posedge clock); while (!req_ch.ready);
      hist.note_row(r);
   endtask

   // stop sending and wait until every expected word has come back
   task automatic wait_drained(int settle);
      req_ch.valid <= 1'b0;
      while (hist.outstanding() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      hist.set_limit(value);
   endtask

   // stimulus
   initial begin
      logic [LIMIT_W-1:0] seg_limit [SEGMENTS];
      logic [KEY_W-1:0]   cur_user;
      logic [KEY_W-1:0]   next_user;
      int                 sent;
      int                 run_len;
      bit                 first_run;
      bit                 fill_run;

      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_ch.valid       = 1'b0;
      req_ch.user_key    = '0;
      req_ch.item_key    = '0;
      req_ch.rating_bits = '0;
      req_ch.row_index   = '0;
      rsp_ch.ready       = 1'b0;
      send_idle_pct      = 31;
      recv_idle_pct      = 60;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: all-ones user first, field extremes, user changes
      send_row('{NO_USER, 32'h0000_0000, 32'h0000_0000, 16'h0000});
      send_row('{NO_USER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF});
      send_row('{32'h0000_0000, 32'h0000_0001, 32'h3F80_0000, 16'h0001});
      send_row('{32'h0000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 16'h5555});
      send_row('{32'h0000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA});
      send_row('{32'h0000_0000, 32'h8000_0000, 32'hBF80_0000, 16'h8000});
      send_row('{32'h8000_0000, 32'h0000_0002, 32'h4000_0000, 16'h0002});
      send_row('{32'h8000_0000, 32'h0000_0003, 32'h4040_0000, 16'h0003});

      // history limit of zero: always empty
      wait_drained(4);
      write_limit(6'd0);
      send_row('{32'h8000_0000, 32'h0000_0004, 32'h4080_0000, 16'h0004});
      send_row('{32'h8000_0000, 32'h0000_0005, 32'h40A0_0000, 16'h0005});

      // limit of one: only the newest entry
      wait_drained(4);
      write_limit(6'd1);
      send_row('{32'h8000_0000, 32'h0000_0006, 32'h40C0_0000, 16'h0006});
      send_row('{32'h8000_0000, 32'h0000_0007, 32'h40E0_0000, 16'h0007});

      // limit above the ring depth
      wait_drained(4);
      write_limit(6'd63);
      send_row('{32'h8000_0000, 32'h0000_0008, 32'h4100_0000, 16'h0008});
      send_row('{32'h8000_0000, 32'h0000_0009, 32'h4110_0000, 16'h0009});
      send_row('{32'h7FFF_FFFF, 32'h0000_000A, 32'h4120_0000, 16'h000A});
      send_row('{32'h7FFF_FFFF, 32'h0000_000B, 32'h4130_0000, 16'h000B});
      cur_user = 32'h7FFF_FFFF;

      // random runs of rows per user, two limit settings per idling phase
      seg_limit[0] = 6'd32;
      seg_limit[1] = 6'd63;
      seg_limit[2] = 6'd0;
      seg_limit[3] = 6'd1;
      seg_limit[4] = 6'd33;
      seg_limit[5] = LIMIT_W'($urandom_range(2, 31));
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         wait_drained(4);
         case (seg / 2)
            0: begin
               send_idle_pct = 31;
               recv_idle_pct = 60;
            end
            1: begin
               send_idle_pct = 60;
               recv_idle_pct = 31;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         write_limit(seg_limit[seg]);
         sent      = 0;
         first_run = 1'b1;
         while (sent < SEGMENT_ROWS) begin
            // sometimes carry the current user over the limit change
            if (!(first_run && $urandom_range(0, 1) == 1)) begin
               do begin
                  next_user = ($urandom_range(0, 7) == 0) ? NO_USER : KEY_W'($urandom);
               end while (next_user == cur_user);
               cur_user = next_user;
            end
            // a first run at a limit of 32 or more fills and wraps the ring; other runs stay within the segment
            fill_run = first_run && (seg_limit[seg] >= 6'd32);
            if (fill_run || $urandom_range(0, 3) == 0)
               run_len = $urandom_range(33, 36);
            else
               run_len = $urandom_range(1, 6);
            if (!fill_run && run_len > SEGMENT_ROWS - sent)
               run_len = SEGMENT_ROWS - sent;
            for (int i = 0; i < run_len; i++) begin
               send_row('{cur_user, KEY_W'($urandom), KEY_W'($urandom),
                          ROW_W'($urandom_range(0, 65535))});
               sent++;
            end
            first_run = 1'b0;
         end
      end

      wait_drained(ROW_LATENCY);
      if (hist.errors == 0 && hist.outstanding() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // hang guard
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
